// File: design/ritoa_pkg.sv
// Shared types and constants for the radix integer to ASCII converter.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ritoa_pkg;

	localparam int VALUE_W     = 64;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 7;
	localparam int COUNT_W     = 7;
	localparam int MAX_DIGITS  = 64;
	localparam int ADDR_W      = $clog2(MAX_DIGITS);
	localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int STEP_BITS   = 8;
	localparam int DIV_STEPS   = VALUE_W / STEP_BITS;
	localparam int STEP_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] RADIX_DEFAULT = RADIX_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
	} in_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  ascii_char;
		logic               last_digit;
		logic [COUNT_W-1:0] digit_count;
	} out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic store;
		logic rd;
	} cmd_t;

	typedef struct packed {
		logic more;
		logic rd_last;
	} sts_t;

endpackage

`default_nettype wire

// File: design/radix_integer_to_ascii_top.sv
// Top level of the radix integer to ASCII converter.
// Depends on ritoa_pkg, ritoa_ctrl and ritoa_dp.
//
// Usage:
//   Drive operand (value, radix) and raise start; the beat is taken at a
//   rising edge where start is high and busy is low. A radix outside 2 to 16
//   converts as radix 10.
//   Characters leave most significant first on result, one per cycle, each
//   marked by strobe for exactly one cycle. The final character carries
//   last_digit and the digit count; others carry a count of zero.
// Sequence, for a value of N digits:
//   a load; per digit, division steps of 8 bits each through the shared
//   remainder unit and a store into the digit memory; then N reads from
//   the digit memory. busy is high from the accepting edge through the last
//   read. Each read passes the digit_s1 stage and the output register; the
//   characters come with no gap. A new beat may be taken as soon as busy falls.
// Reset clears the controller and the strobe; no clearing pass is needed.
// The receiver cannot stall: every strobed character must be taken.
`timescale 1ns / 1ps
`default_nettype none

module radix_integer_to_ascii_top import ritoa_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	input  in_t  operand,
	output logic busy,
	output logic strobe,
	output out_t result
);

	cmd_t cmd;
	sts_t sts;

	ritoa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ritoa_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand),
		.cmd     (cmd),
		.sts     (sts),
		.strobe  (strobe),
		.result  (result)
	);

	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.last_digit == (result.digit_count != '0)))
		else $error("digit count does not match last mark");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((result.ascii_char >= CHAR_ZERO && result.ascii_char <= CHAR_W'(57)) ||
			(result.ascii_char >= CHAR_A && result.ascii_char <= CHAR_W'(70))))
		else $error("character outside digit range");

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last_digit) |=> strobe)
		else $error("gap inside a character run");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

endmodule

`default_nettype wire

// File: design/ritoa_ctrl.sv
// Controller for the converter: sequences load, division steps, digit store
// and read-out. Depends on ritoa_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module ritoa_ctrl import ritoa_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_STORE = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]            state_q;
	logic [1:0]            state_n;
	logic [STEP_CNT_W-1:0] step_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (step_q == STEP_CNT_W'(DIV_STEPS - 1)) begin
					state_n = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_n   = sts.more ? ST_DIV : ST_EMIT;
			end
			ST_EMIT: begin
				cmd.rd = 1'b1;
				if (sts.rd_last) begin
					state_n = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.step) begin
				step_q <= step_q + STEP_CNT_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/ritoa_dp.sv
// Datapath for the converter: digit-serial divider, digit buffer memory and
// output register. Depends on ritoa_pkg; driven by ritoa_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module ritoa_dp import ritoa_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  in_t  operand,
	input  cmd_t cmd,
	output sts_t sts,
	output logic strobe,
	output out_t result
);

	logic [VALUE_W-1:0]   dvd_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [CNT_W-1:0]     have_q;
	logic [ADDR_W-1:0]    rd_ptr_q;
	logic [DIGIT_W-1:0]   mem_q [MAX_DIGITS];

	logic [DIGIT_W-1:0]   rem_n;
	logic [RADIX_W-1:0]   trial;
	logic [STEP_BITS-1:0] q_bits;
	logic [RADIX_W-1:0]   radix_n;

	logic                 rd_v_s1;
	logic                 last_s1;
	logic [CNT_W-1:0]     cnt_s1;
	logic [DIGIT_W-1:0]   digit_s1;

	logic                 strobe_q;
	out_t                 result_q;

	function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
		if (d < DIGIT_W'(10)) begin
			return CHAR_ZERO + CHAR_W'(d);
		end
		return CHAR_A + CHAR_W'(d) - CHAR_W'(10);
	endfunction

	assign radix_n = (operand.radix < RADIX_MIN || operand.radix > RADIX_MAX) ?
		RADIX_DEFAULT : operand.radix;

	always_comb begin
		rem_n  = rem_q;
		trial  = '0;
		q_bits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {rem_n, dvd_q[VALUE_W-1-i]};
			if (trial >= radix_q) begin
				rem_n                  = DIGIT_W'(trial - radix_q);
				q_bits[STEP_BITS-1-i]  = 1'b1;
			end else begin
				rem_n = trial[DIGIT_W-1:0];
			end
		end
	end

	assign sts.more    = (dvd_q != '0) && (have_q < CNT_W'(MAX_DIGITS - 1));
	assign sts.rd_last = (rd_ptr_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q   <= operand.value;
			radix_q <= radix_n;
			rem_q   <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[VALUE_W-STEP_BITS-1:0], q_bits};
			rem_q <= rem_n;
		end else if (cmd.store) begin
			rem_q <= '0;
		end
		if (cmd.store) begin
			mem_q[have_q[ADDR_W-1:0]] <= rem_q;
			rd_ptr_q                  <= have_q[ADDR_W-1:0];
		end else if (cmd.rd) begin
			rd_ptr_q <= rd_ptr_q - ADDR_W'(1);
		end
		if (cmd.rd) begin
			digit_s1 <= mem_q[rd_ptr_q];
			last_s1  <= (rd_ptr_q == '0);
			cnt_s1   <= (rd_ptr_q == '0) ? have_q : '0;
		end
		result_q.ascii_char  <= ascii_of(digit_s1);
		result_q.last_digit  <= last_s1;
		result_q.digit_count <= COUNT_W'(cnt_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= '0;
			rd_v_s1  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				have_q <= '0;
			end else if (cmd.store) begin
				have_q <= have_q + CNT_W'(1);
			end
			rd_v_s1  <= cmd.rd;
			strobe_q <= rd_v_s1;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for radix_integer_to_ascii_top: directed and random conversions,
// with each character checked against a behavioral digit speller.
// Depends on ritoa_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module testbench;
	import ritoa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_t operand = '0;
	logic busy;
	logic strobe;
	out_t result;

	out_t pending_chars[$];
	int errors = 0;

	radix_integer_to_ascii_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operand(operand),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	always #5 clk = ~clk;

	initial begin
		#12_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void spell_digits(input logic [VALUE_W-1:0] value,
			input logic [RADIX_W-1:0] radix);
		logic [VALUE_W-1:0] rest;
		logic [VALUE_W-1:0] base;
		logic [DIGIT_W-1:0] digits [MAX_DIGITS];
		int n;
		out_t ch;
		base = VALUE_W'((radix < RADIX_MIN || radix > RADIX_MAX) ? RADIX_DEFAULT : radix);
		rest = value;
		n = 0;
		if (rest == '0) begin
			digits[0] = '0;
			n = 1;
		end else begin
			while (rest != '0 && n < MAX_DIGITS) begin
				digits[n] = DIGIT_W'(rest % base);
				rest = rest / base;
				n++;
			end
		end
		for (int k = n - 1; k >= 0; k--) begin
			ch.ascii_char = (digits[k] < 10) ? CHAR_ZERO + CHAR_W'(digits[k])
				: CHAR_A + CHAR_W'(digits[k] - 10);
			ch.last_digit = (k == 0);
			ch.digit_count = (k == 0) ? COUNT_W'(n) : '0;
			pending_chars.push_back(ch);
		end
	endfunction

	always @(posedge clk) begin
		out_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected character beat: ascii_char %0d", result.ascii_char);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				if (result.ascii_char !== want.ascii_char) begin
					$error("ascii_char: expected %0d, actual %0d",
						want.ascii_char, result.ascii_char);
					errors++;
				end
				if (result.last_digit !== want.last_digit) begin
					$error("last_digit: expected %0d, actual %0d",
						want.last_digit, result.last_digit);
					errors++;
				end
				if (result.digit_count !== want.digit_count) begin
					$error("digit_count: expected %0d, actual %0d",
						want.digit_count, result.digit_count);
					errors++;
				end
			end
		end
	end

	task automatic send_beat(input logic [VALUE_W-1:0] value,
			input logic [RADIX_W-1:0] radix, input bit may_idle);
		in_t beat;
		beat.value = value;
		beat.radix = radix;
		start <= 1'b1;
		operand <= beat;
		do @(posedge clk); while (busy);
		spell_digits(value, radix);
		if (may_idle && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain_chars();
		start <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic test_every_radix();
		for (int r = 2; r <= 16; r++)
			send_beat({VALUE_W{1'b1}}, RADIX_W'(r), 1'b1);
	endtask

	task automatic test_radix_out_of_range();
		send_beat(64'd12345, RADIX_W'(0), 1'b1);
		send_beat(64'd987654321, RADIX_W'(1), 1'b1);
		send_beat(64'd4096, RADIX_W'(17), 1'b1);
		send_beat({VALUE_W{1'b1}}, RADIX_W'(31), 1'b1);
	endtask

	task automatic test_zero_value();
		send_beat('0, RADIX_DEFAULT, 1'b1);
		send_beat('0, RADIX_W'(0), 1'b0);
	endtask

	task automatic test_extremes();
		send_beat(64'd1, RADIX_MIN, 1'b0);
		send_beat(64'h8000_0000_0000_0000, RADIX_MIN, 1'b1);
		send_beat(64'hFEDC_BA98_7654_3210, RADIX_MAX, 1'b1);
	endtask

	task automatic test_random(input int count, input bit may_idle);
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: value = '0;
				1: value = VALUE_W'($urandom_range(0, 300));
				default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
			endcase
			if ($urandom_range(0, 9) == 0)
				radix = RADIX_W'($urandom_range(0, 31));
			else
				radix = RADIX_W'($urandom_range(2, 16));
			send_beat(value, radix, may_idle);
		end
	endtask

	task automatic test_pause_until_drained();
		drain_chars();
		repeat ($urandom_range(1, 12)) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_every_radix();
		test_radix_out_of_range();
		test_zero_value();
		test_extremes();
		test_random(200, 1'b1);
		test_pause_until_drained();
		test_random(200, 1'b1);
		test_random(60, 1'b0);
		drain_chars();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
